// ===== design/ise_pkg.sv =====
// ----------------------------------------------------------------------------
// ise_pkg - shared types for the insertion sort engine
// Word type and the structs that link neighboring sort cells.
// ----------------------------------------------------------------------------
`default_nettype none

package ise_pkg;

   localparam int WORD_W = 32;

   typedef logic signed [WORD_W-1:0] word_type;

   // What one cell shows its neighbors.
   typedef struct packed {
      word_type value;
      logic     valid;
      logic     greater;   // stored value is above the value being inserted
   } cell_link_type;

   // Broadcast control from the top level to every cell.
   typedef struct packed {
      logic     insert;
      logic     shift;
      word_type value;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== design/ise_req_if.sv =====
// ----------------------------------------------------------------------------
// ise_req_if - input channel of the insertion sort engine
// Valid/ready channel carrying one value and its end-of-run flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface ise_req_if;
   logic               valid;
   logic               ready;
   ise_pkg::word_type  value;
   logic               final_item;

   modport source (output valid, output value, output final_item, input ready);
   modport sink   (input valid, input value, input final_item, output ready);
endinterface

`default_nettype wire

// ===== design/ise_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ise_rsp_if - result channel of the insertion sort engine
// Valid/ready channel carrying one sorted value and its run flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface ise_rsp_if;
   logic               valid;
   logic               ready;
   ise_pkg::word_type  sorted_value;
   logic               final_result;
   logic               overflow;

   modport source (output valid, output sorted_value, output final_result,
                   output overflow, input ready);
   modport sink   (input valid, input sorted_value, input final_result,
                   input overflow, output ready);
endinterface

`default_nettype wire

// ===== design/ise_cell.sv =====
// ----------------------------------------------------------------------------
// ise_cell - one slot of the systolic sort chain
// Holds one value; takes the inserted value or its left neighbor's on insert,
// and its right neighbor's on shift.
// ----------------------------------------------------------------------------
`default_nettype none

module ise_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ise_pkg::cell_ctrl_type ctrl,
   input  wire ise_pkg::cell_link_type prev_link,
   input  wire ise_pkg::cell_link_type next_link,
   output      ise_pkg::cell_link_type link
);

   ise_pkg::word_type value_ff, value_in;
   logic              valid_ff, valid_in;
   logic              greater;
   logic              take;

   // Strict compare keeps equal values in arrival order.
   assign greater = valid_ff && (value_ff > ctrl.value);
   assign take    = greater || (!valid_ff && prev_link.valid);

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctrl.shift) begin
         value_in = next_link.value;
         valid_in = next_link.valid;
      end else if (ctrl.insert && take) begin
         value_in = prev_link.greater ? prev_link.value : ctrl.value;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign link.value   = value_ff;
   assign link.valid   = valid_ff;
   assign link.greater = greater;

endmodule

`default_nettype wire

// ===== design/insertion_sort_engine_core.sv =====
// ----------------------------------------------------------------------------
// insertion_sort_engine_core - stable streaming insertion sorter
// Loads a run of signed values into a chain of sort cells, then drains the
// run in ascending order once the flagged last value has arrived.
// ----------------------------------------------------------------------------
//
//   channel  dir  payload                                  transaction when
//   -------  ---  ---------------------------------------  -----------------
//   req_port in   value, final_item                        valid && ready
//   rsp_port out  sorted_value, final_result, overflow     valid && ready
//
// Loading takes one value per cycle while no run drains; every cell
// compares the new value at once and the larger ones step right in the
// same cycle. Draining gives one result per cycle while rsp_port.ready is
// high, paced by the chain shifting left toward cell 0.
// Reset clears the cell valid bits, the drain state and the overflow flag.
// req_port.ready is low while a run drains; a stalled result holds cell 0.
// ----------------------------------------------------------------------------
`default_nettype none

module insertion_sort_engine_core #(
   parameter int DEPTH = 64
) (
   input  wire logic clock,
   input  wire logic reset,
   ise_req_if.sink   req_port,
   ise_rsp_if.source rsp_port
);

   ise_pkg::cell_ctrl_type ctrl;
   ise_pkg::cell_link_type links      [DEPTH];
   ise_pkg::cell_link_type prev_links [DEPTH];
   ise_pkg::cell_link_type next_links [DEPTH];

   logic draining_ff, draining_in;
   logic dropped_ff,  dropped_in;
   logic req_fire;
   logic rsp_fire;
   logic store_full;
   logic run_done;

   // Hold off new values while a run drains.
   assign req_port.ready = !draining_ff;
   assign req_fire       = req_port.valid && req_port.ready;
   assign rsp_fire       = rsp_port.valid && rsp_port.ready;

   // The chain fills from cell 0, so the last cell marks a full store.
   assign store_full = links[DEPTH-1].valid;

   // Last result leaves when cell 1 is already empty.
   assign run_done = rsp_fire && !links[1].valid;

   assign ctrl.insert = req_fire && !store_full;
   assign ctrl.shift  = rsp_fire;
   assign ctrl.value  = req_port.value;

   // Wire up the neighbors; the chain ends see fixed boundary links.
   for (genvar i = 0; i < DEPTH; i++) begin : g_chain
      if (i == 0) begin : g_head
         assign prev_links[i] = '{value: '0, valid: 1'b1, greater: 1'b0};
      end else begin : g_body
         assign prev_links[i] = links[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign next_links[i] = '{value: '0, valid: 1'b0, greater: 1'b0};
      end else begin : g_rest
         assign next_links[i] = links[i+1];
      end

      ise_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .prev_link (prev_links[i]),
         .next_link (next_links[i]),
         .link      (links[i])
      );
   end

   always_comb begin
      draining_in = draining_ff;
      dropped_in  = dropped_ff;
      // Drop a value that finds the store full and flag the run.
      if (req_fire && store_full) begin
         dropped_in = 1'b1;
      end
      // Start draining on the last value of the run.
      if (req_fire && req_port.final_item) begin
         draining_in = 1'b1;
      end
      // Close the run once its last result has gone out.
      if (run_done) begin
         draining_in = 1'b0;
         dropped_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         draining_ff <= 1'b0;
         dropped_ff  <= 1'b0;
      end else begin
         draining_ff <= draining_in;
         dropped_ff  <= dropped_in;
      end
   end

   // Cell 0 always holds the smallest remaining value during a drain.
   assign rsp_port.valid        = draining_ff;
   assign rsp_port.sorted_value = links[0].value;
   assign rsp_port.final_result = !links[1].valid;
   assign rsp_port.overflow     = dropped_ff;

endmodule

`default_nettype wire
